// ===== rtl/lprf_pkg.sv =====
// Package for the lidar point range filter: field widths, configuration
// register codes, mode and tag codes, and the constant divider for time.
// No dependencies; every other file of the block imports it.
package lprf_pkg;

  // Coordinate magnitude bits; coordinate fields are one bit wider (sign)
  localparam int unsigned COORD_WIDTH_DEF = 18;
  localparam int unsigned FIFO_DEPTH_DEF  = 4;

  // Fixed field widths
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned LIM_W   = 18;
  localparam int unsigned DEC_W   = 16;
  localparam int unsigned TAG_W   = 8;
  localparam int unsigned INT_W   = 16;
  localparam int unsigned RING_W  = 8;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned RANGE_W = 19;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = LIM_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LIDAR_MODE = 2'd0,
    CFG_MIN_RANGE  = 2'd1,
    CFG_MAX_RANGE  = 2'd2,
    CFG_DECIMATION = 2'd3
  } cfg_idx_e;

  // Reset values of the registers
  localparam logic [MODE_W-1:0] MODE_RST      = 2'd0;
  localparam logic [LIM_W-1:0]  MIN_RANGE_RST = 18'd0;
  localparam logic [LIM_W-1:0]  MAX_RANGE_RST = 18'h3FFFF;
  localparam logic [DEC_W-1:0]  DECIMATION_RST = 16'd1;

  // Sensor modes (mode 3 acts as nanosecond spinning)
  localparam logic [MODE_W-1:0] MODE_SOLID   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SPIN_US = 2'd1;

  // Solid-state return tag: bits 5:4 must read no return or one return
  localparam logic [TAG_W-1:0] TAG_FIELD_MASK = 8'h30;
  localparam logic [TAG_W-1:0] TAG_RET_NONE   = 8'h00;
  localparam logic [TAG_W-1:0] TAG_RET_ONE    = 8'h10;

  // Shared multiplier, and ns to us: floor(t/1000) = (t * MAGIC) >> 38
  localparam int unsigned       MUL_W         = 32;
  localparam logic [MUL_W-1:0]  DIV1000_MAGIC = 32'd274877907;
  localparam int unsigned       DIV1000_SHIFT = 38;

  // Bits of a queue entry behind the coordinates: intensity, ring, time
  localparam int unsigned ENTRY_TAIL_W = INT_W + RING_W + TIME_W;

  typedef struct packed {
    logic [MODE_W-1:0] lidar_mode;
    logic [LIM_W-1:0]  min_range_mm;
    logic [LIM_W-1:0]  max_range_mm;
    logic [DEC_W-1:0]  decimation;
  } cfg_t;

endpackage

// ===== rtl/lprf_in_if.sv =====
// Input point channel: valid/ready handshake plus the point fields.
// Depends on lprf_pkg.
interface lprf_in_if #(
  parameter int unsigned COORD_WIDTH = lprf_pkg::COORD_WIDTH_DEF
) ();
  import lprf_pkg::*;

  localparam int unsigned CW = COORD_WIDTH + 1;

  logic                 valid;
  logic                 ready;
  logic                 frame_start;
  logic                 point_finite;
  logic signed [CW-1:0] x_mm;
  logic signed [CW-1:0] y_mm;
  logic signed [CW-1:0] z_mm;
  logic [TAG_W-1:0]     return_tag;
  logic [INT_W-1:0]     intensity_in;
  logic [RING_W-1:0]    ring_in;
  logic [TIME_W-1:0]    raw_time;

  modport source (
    output valid, frame_start, point_finite, x_mm, y_mm, z_mm,
           return_tag, intensity_in, ring_in, raw_time,
    input  ready
  );

  modport sink (
    input  valid, frame_start, point_finite, x_mm, y_mm, z_mm,
           return_tag, intensity_in, ring_in, raw_time,
    output ready
  );
endinterface

// ===== rtl/lprf_out_if.sv =====
// Output point channel: valid/ready handshake plus the kept point fields.
// Depends on lprf_pkg.
interface lprf_out_if #(
  parameter int unsigned COORD_WIDTH = lprf_pkg::COORD_WIDTH_DEF
) ();
  import lprf_pkg::*;

  localparam int unsigned CW = COORD_WIDTH + 1;

  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] x_out;
  logic signed [CW-1:0] y_out;
  logic signed [CW-1:0] z_out;
  logic [INT_W-1:0]     intensity_out;
  logic [RING_W-1:0]    ring_out;
  logic [TIME_W-1:0]    time_us;
  logic [RANGE_W-1:0]   range_mm;

  modport source (
    output valid, x_out, y_out, z_out, intensity_out, ring_out, time_us,
           range_mm,
    input  ready
  );

  modport sink (
    input  valid, x_out, y_out, z_out, intensity_out, ring_out, time_us,
           range_mm,
    output ready
  );
endinterface

// ===== rtl/lprf_front.sv =====
// Front end: accepts points, keeps frame index and previous point, queues
// finite points past decimation and solid-state tag and duplicate checks.
// Depends on lprf_pkg and lprf_in_if.
module lprf_front #(
  parameter int unsigned COORD_WIDTH = lprf_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ENTRY_W     = 3 * (COORD_WIDTH + 1) + 1 + lprf_pkg::ENTRY_TAIL_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lprf_pkg::cfg_t       cfg_i,
  lprf_in_if.sink              pts_i,
  input  logic                 full_i,
  output logic                 push_o,
  output logic [ENTRY_W-1:0]   entry_o
);
  import lprf_pkg::*;

  localparam int unsigned CW = COORD_WIDTH + 1;

  logic [DEC_W-1:0] phase_q, phase_d;
  logic             seen_q, seen_d;
  logic [CW-1:0]    prev_x_q, prev_y_q, prev_z_q;

  logic [DEC_W-1:0] dec_eff, phase_cur;
  logic [DEC_W:0]   phase_inc;
  logic             seen_cur, same, dec_pass, solid, tag_ok, accept, keep;
  logic [TAG_W-1:0] tag_field;

  assign pts_i.ready = !full_i;
  assign accept      = pts_i.valid && pts_i.ready;

  // Frame start clears index and previous point ahead of this point
  assign phase_cur = pts_i.frame_start ? '0 : phase_q;
  assign seen_cur  = pts_i.frame_start ? 1'b0 : seen_q;

  // A decimation of zero acts as one
  assign dec_eff   = (cfg_i.decimation == '0) ? DEC_W'(1) : cfg_i.decimation;
  assign phase_inc = {1'b0, phase_cur} + (DEC_W + 1)'(1);
  assign dec_pass  = (phase_cur == '0) || (phase_cur >= dec_eff);

  // Duplicate of the previous counted point (only once one exists)
  assign same = seen_cur
             && (pts_i.x_mm == prev_x_q)
             && (pts_i.y_mm == prev_y_q)
             && (pts_i.z_mm == prev_z_q);

  assign solid     = (cfg_i.lidar_mode == MODE_SOLID);
  assign tag_field = pts_i.return_tag & TAG_FIELD_MASK;
  assign tag_ok    = (tag_field == TAG_RET_NONE) || (tag_field == TAG_RET_ONE);

  assign keep   = pts_i.point_finite && dec_pass
               && (!solid || (tag_ok && seen_cur && !same));
  assign push_o = accept && keep;

  assign entry_o = {solid, pts_i.x_mm, pts_i.y_mm, pts_i.z_mm,
                    pts_i.intensity_in, pts_i.ring_in, pts_i.raw_time};

  // Next index phase and first-point flag
  always_comb begin
    phase_d = phase_cur;
    seen_d  = seen_cur;
    if (pts_i.point_finite) begin
      phase_d = (phase_inc >= {1'b0, dec_eff}) ? '0 : phase_inc[DEC_W-1:0];
      seen_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      seen_q  <= 1'b0;
    end else if (accept) begin
      phase_q <= phase_d;
      seen_q  <= seen_d;
    end
  end

  // Previous point; only compared while seen_q is set
  always_ff @(posedge clk_i) begin
    if (accept && pts_i.point_finite) begin
      prev_x_q <= pts_i.x_mm;
      prev_y_q <= pts_i.y_mm;
      prev_z_q <= pts_i.z_mm;
    end
  end

endmodule

// ===== rtl/lprf_fifo.sv =====
// Short queue of candidate points between the front end and the back end.
// Depends on lprf_pkg (defaults only).
module lprf_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = lprf_pkg::FIFO_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import lprf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Queue discipline
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from an empty queue");
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule

// ===== rtl/lprf_back.sv =====
// Back end: squared range and limits on one shared multiplier, range test,
// time scaling, bit-serial square root and the output register.
// Depends on lprf_pkg and lprf_out_if.
module lprf_back #(
  parameter int unsigned COORD_WIDTH = lprf_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ENTRY_W     = 3 * (COORD_WIDTH + 1) + 1 + lprf_pkg::ENTRY_TAIL_W
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lprf_pkg::cfg_t       cfg_i,
  input  logic                 empty_i,
  input  logic [ENTRY_W-1:0]   entry_i,
  output logic                 pop_o,
  lprf_out_if.source           pts_o
);
  import lprf_pkg::*;

  localparam int unsigned CW     = COORD_WIDTH + 1;
  localparam int unsigned ACC_W  = (2 * COORD_WIDTH + 2 > 64) ? 64 : 2 * COORD_WIDTH + 2;
  localparam int unsigned RAD_W  = 2 * LIM_W;
  localparam int unsigned ROOT_W = LIM_W;
  localparam int unsigned REM_W  = ROOT_W + 2;
  localparam int unsigned SQC_W  = $clog2(ROOT_W);

  typedef enum logic [2:0] {
    BS_IDLE, BS_MUL, BS_CMP, BS_SQRT, BS_OUT
  } back_state_e;

  typedef enum logic [2:0] {
    MS_X, MS_Y, MS_Z, MS_MIN, MS_MAX, MS_TIME, MS_DONE
  } mul_step_e;

  back_state_e state_q;
  mul_step_e   issue_q, kind_q;

  // Working copy of the point
  logic                 solid_q;
  logic [CW-1:0]        x_q, y_q, z_q;
  logic [INT_W-1:0]     int_q;
  logic [RING_W-1:0]    ring_q;
  logic [TIME_W-1:0]    raw_time_q, time_q;

  // Arithmetic
  logic [2*MUL_W-1:0]   prod_q;
  logic [ACC_W-1:0]     acc_q;
  logic                 ovf_q;
  logic [RAD_W-1:0]     lo2_q, hi2_q, rad_q;
  logic [REM_W-1:0]     rem_q;
  logic [ROOT_W-1:0]    root_q;
  logic [SQC_W-1:0]     sq_cnt_q;

  // Output register
  logic                 out_valid_q;
  logic [CW-1:0]        x_out_q, y_out_q, z_out_q;
  logic [INT_W-1:0]     int_out_q;
  logic [RING_W-1:0]    ring_out_q;
  logic [TIME_W-1:0]    time_out_q;
  logic [RANGE_W-1:0]   range_out_q;

  logic [CW-1:0]        mag_x, mag_y, mag_z;
  logic [MUL_W-1:0]     op_a, op_b;
  logic [ACC_W:0]       acc_sum;
  logic [63:0]          acc64;
  logic                 big, range_ok, out_load;
  logic [REM_W+1:0]     rem_ext, trial;

  function automatic logic [CW-1:0] f_abs(logic [CW-1:0] v);
    // Two's complement magnitude; the most negative value maps to 2^(CW-1)
    return v[CW-1] ? (~v + CW'(1)) : v;
  endfunction

  assign mag_x = f_abs(x_q);
  assign mag_y = f_abs(y_q);
  assign mag_z = f_abs(z_q);

  assign pop_o = (state_q == BS_IDLE) && !empty_i;

  // Output register takes a new item when empty or drained this cycle
  assign out_load = (state_q == BS_OUT) && (!out_valid_q || pts_o.ready);

  // Operand select for the shared multiplier
  always_comb begin
    unique case (issue_q)
      MS_X:    begin op_a = MUL_W'(mag_x);     op_b = MUL_W'(mag_x);  end
      MS_Y:    begin op_a = MUL_W'(mag_y);     op_b = MUL_W'(mag_y);  end
      MS_Z:    begin op_a = MUL_W'(mag_z);     op_b = MUL_W'(mag_z);  end
      MS_MIN:  begin op_a = MUL_W'(cfg_i.min_range_mm);
                     op_b = MUL_W'(cfg_i.min_range_mm); end
      MS_MAX:  begin op_a = MUL_W'(cfg_i.max_range_mm);
                     op_b = MUL_W'(cfg_i.max_range_mm); end
      MS_TIME: begin op_a = raw_time_q;        op_b = DIV1000_MAGIC;  end
      default: begin op_a = '0;                op_b = '0;             end
    endcase
  end

  // Squared range accumulation; a carry out marks an oversized range
  assign acc_sum = (ACC_W + 1)'(acc_q) + (ACC_W + 1)'(prod_q);

  // Range test: oversized magnitude or sum fails in every mode
  assign acc64 = 64'(acc_q);
  assign big   = ((64'(mag_x) >> MUL_W) != 64'd0)
              || ((64'(mag_y) >> MUL_W) != 64'd0)
              || ((64'(mag_z) >> MUL_W) != 64'd0);
  always_comb begin
    if (ovf_q || big) begin
      range_ok = 1'b0;
    end else if (solid_q) begin
      range_ok = (acc64 > 64'(lo2_q)) && (acc64 < 64'(hi2_q));
    end else begin
      range_ok = (acc64 >= 64'(lo2_q)) && (acc64 <= 64'(hi2_q));
    end
  end

  // One root bit per cycle: try appending 1 to the partial root
  assign rem_ext = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial   = (REM_W + 2)'({root_q, 2'b01});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BS_IDLE;
      issue_q     <= MS_DONE;
      kind_q      <= MS_DONE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (pts_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        // Take the next candidate from the queue
        BS_IDLE: begin
          if (!empty_i) begin
            solid_q    <= entry_i[ENTRY_W-1];
            x_q        <= entry_i[ENTRY_W-2 -: CW];
            y_q        <= entry_i[ENTRY_W-2-CW -: CW];
            z_q        <= entry_i[ENTRY_W-2-2*CW -: CW];
            int_q      <= entry_i[TIME_W+RING_W +: INT_W];
            ring_q     <= entry_i[TIME_W +: RING_W];
            raw_time_q <= entry_i[TIME_W-1:0];
            acc_q      <= '0;
            ovf_q      <= 1'b0;
            issue_q    <= MS_X;
            kind_q     <= MS_DONE;
            state_q    <= BS_MUL;
          end
        end
        // Issue one product per cycle, consume the one before
        BS_MUL: begin
          if (issue_q != MS_DONE) begin
            prod_q  <= 64'(op_a) * 64'(op_b);
            issue_q <= mul_step_e'(issue_q + 3'd1);
          end
          kind_q <= issue_q;
          case (kind_q) inside
            MS_X, MS_Y, MS_Z: begin
              acc_q <= acc_sum[ACC_W-1:0];
              ovf_q <= ovf_q | acc_sum[ACC_W];
            end
            MS_MIN:  lo2_q <= prod_q[RAD_W-1:0];
            MS_MAX:  hi2_q <= prod_q[RAD_W-1:0];
            MS_TIME: begin
              time_q  <= (cfg_i.lidar_mode == MODE_SPIN_US)
                       ? raw_time_q
                       : TIME_W'(prod_q[2*MUL_W-1:DIV1000_SHIFT]);
              state_q <= BS_CMP;
            end
            default: ;
          endcase
        end
        // Drop, finish a solid-state point, or start the square root
        BS_CMP: begin
          root_q <= '0;
          if (!range_ok) begin
            state_q <= BS_IDLE;
          end else if (solid_q) begin
            state_q <= BS_OUT;
          end else begin
            rad_q    <= acc64[RAD_W-1:0];
            rem_q    <= '0;
            sq_cnt_q <= SQC_W'(ROOT_W - 1);
            state_q  <= BS_SQRT;
          end
        end
        BS_SQRT: begin
          rad_q <= rad_q << 2;
          if (rem_ext >= trial) begin
            rem_q  <= REM_W'(rem_ext - trial);
            root_q <= {root_q[ROOT_W-2:0], 1'b1};
          end else begin
            rem_q  <= REM_W'(rem_ext);
            root_q <= {root_q[ROOT_W-2:0], 1'b0};
          end
          if (sq_cnt_q == '0) begin
            state_q <= BS_OUT;
          end else begin
            sq_cnt_q <= sq_cnt_q - SQC_W'(1);
          end
        end
        // Load the output register once it is free
        BS_OUT: begin
          if (out_load) begin
            x_out_q     <= x_q;
            y_out_q     <= y_q;
            z_out_q     <= z_q;
            int_out_q   <= int_q;
            ring_out_q  <= solid_q ? '0 : ring_q;
            time_out_q  <= time_q;
            range_out_q <= RANGE_W'(root_q);
            state_q     <= BS_IDLE;
          end
        end
        default: state_q <= BS_IDLE;
      endcase
    end
  end

  assign pts_o.valid         = out_valid_q;
  assign pts_o.x_out         = x_out_q;
  assign pts_o.y_out         = y_out_q;
  assign pts_o.z_out         = z_out_q;
  assign pts_o.intensity_out = int_out_q;
  assign pts_o.ring_out      = ring_out_q;
  assign pts_o.time_us       = time_out_q;
  assign pts_o.range_mm      = range_out_q;

  // A pop always starts a fresh multiply sequence
  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == BS_MUL) && (issue_q == MS_X) && (kind_q == MS_DONE))
    else $error("pop did not start a multiply sequence");
  // A finished result waits while the output slot is still held
  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BS_OUT) && out_valid_q && !pts_o.ready |=> (state_q == BS_OUT))
    else $error("result overwrote a pending output");
  // A new output item only comes from the output state
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == BS_OUT))
    else $error("output valid raised outside the output state");

endmodule

// ===== rtl/lidar_point_range_filter_unit.sv =====
// Top level of the lidar point range filter: configuration registers,
// front end, candidate queue and back end.
// Depends on lprf_pkg, lprf_in_if, lprf_out_if, lprf_front, lprf_fifo, lprf_back.
//
//   Port        Role     Handshake        Carries
//   pts_i       sink     valid / ready    one lidar point per item
//   pts_o       source   valid / ready    one kept point per item
//   cfg_*_i     write    cfg_we_i only    mode, range limits, decimation
//
// The front end takes one point per cycle while the queue has room; points it
// drops (not finite, decimated, bad tag, first or repeated point) are not queued.
// The back end works on one queued point at a time: six products through one
// shared multiplier, then, in the spinning modes if the range test keeps the
// point, an 18-step bit-serial square root.
// Reset clears the registers, the frame state and the queue; a stalled output
// holds its item while the front end keeps filling the queue.
module lidar_point_range_filter_unit #(
  parameter int unsigned COORD_WIDTH = lprf_pkg::COORD_WIDTH_DEF,
  parameter int unsigned FIFO_DEPTH  = lprf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  lprf_in_if.sink                             pts_i,
  lprf_out_if.source                          pts_o,
  input  logic                                cfg_we_i,
  input  logic [lprf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lprf_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import lprf_pkg::*;

  localparam int unsigned ENTRY_W = 3 * (COORD_WIDTH + 1) + 1 + ENTRY_TAIL_W;

  cfg_t               cfg_q;
  logic               push, pop, full, empty;
  logic [ENTRY_W-1:0] push_entry, pop_entry;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lidar_mode   <= MODE_RST;
      cfg_q.min_range_mm <= MIN_RANGE_RST;
      cfg_q.max_range_mm <= MAX_RANGE_RST;
      cfg_q.decimation   <= DECIMATION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LIDAR_MODE: cfg_q.lidar_mode   <= cfg_data_i[MODE_W-1:0];
        CFG_MIN_RANGE:  cfg_q.min_range_mm <= cfg_data_i[LIM_W-1:0];
        CFG_MAX_RANGE:  cfg_q.max_range_mm <= cfg_data_i[LIM_W-1:0];
        CFG_DECIMATION: cfg_q.decimation   <= cfg_data_i[DEC_W-1:0];
        default: ;
      endcase
    end
  end

  lprf_front #(
    .COORD_WIDTH (COORD_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .pts_i   (pts_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  lprf_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_entry),
    .empty_o (empty)
  );

  lprf_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .ENTRY_W     (ENTRY_W)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .entry_i (pop_entry),
    .pop_o   (pop),
    .pts_o   (pts_o)
  );

endmodule

// ===== sim/tb_lidar_point_range_filter_unit.sv =====
// Self-checking testbench for lidar_point_range_filter_unit: random and directed
// points through valid/ready channels, checked against an in-bench point filter.
// Depends on lprf_pkg, lprf_in_if, lprf_out_if and the unit itself.
`timescale 1ns / 1ps

module tb_lidar_point_range_filter_unit;
  import lprf_pkg::*;

  localparam int unsigned CRD_W      = COORD_WIDTH_DEF + 1;
  localparam int          CRD_MAX    = (1 << COORD_WIDTH_DEF) - 1;
  localparam int          CRD_MIN    = -(1 << COORD_WIDTH_DEF);
  localparam int          CLK_PERIOD = 4;
  localparam int          SETTLE_CYC = 28 * (FIFO_DEPTH_DEF + 2) + 20;
  localparam int          LIMIT_CYC  = 400000;

  // Mode codes not named by the package
  localparam logic [MODE_W-1:0] MODE_SPIN_NS  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPIN_ALT = 2'd3;
  // Tag whose return field is neither of the accepted values
  localparam logic [TAG_W-1:0]  TAG_RET_TWO   = 8'h20;

  typedef struct {
    logic                    frame_start;
    logic                    point_finite;
    logic signed [CRD_W-1:0] x, y, z;
    logic [TAG_W-1:0]        tag;
    logic [INT_W-1:0]        inten;
    logic [RING_W-1:0]       ring;
    logic [TIME_W-1:0]       raw_t;
    bit                      hold;    // sender drains all results first
  } point_t;

  typedef struct {
    logic signed [CRD_W-1:0] x, y, z;
    logic [INT_W-1:0]        inten;
    logic [RING_W-1:0]       ring;
    logic [TIME_W-1:0]       t_us;
    logic [RANGE_W-1:0]      rng;
  } kept_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lprf_in_if  pts_in ();
  lprf_out_if pts_out ();

  lidar_point_range_filter_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pts_i      (pts_in),
    .pts_o      (pts_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Register copies and frame state of the filter model
  logic [MODE_W-1:0]       mode_q = MODE_RST;
  logic [LIM_W-1:0]        min_q  = MIN_RANGE_RST;
  logic [LIM_W-1:0]        max_q  = MAX_RANGE_RST;
  logic [DEC_W-1:0]        dec_q  = DECIMATION_RST;
  logic [DEC_W-1:0]        idx_phase = '0;
  bit                      seen = 1'b0;
  logic signed [CRD_W-1:0] prev_x = '0, prev_y = '0, prev_z = '0;

  point_t pend_q[$];
  kept_t  kept_q[$];
  point_t cur_pt;
  point_t last_gen;
  bit     have_last = 1'b0;
  kept_t  head;

  bit pt_taken  = 1'b0;
  bit res_taken = 1'b0;
  bit quiet     = 1'b0;
  int gap_cnt   = 0;
  int stall_cnt = 0;
  int cyc_cnt   = 0;
  int n_points  = 0;
  int n_kept    = 0;
  int n_errs    = 0;
  int n_cfgs    = 0;

  // Append a point to the list of items still to be sent
  function automatic void queue_pt(input point_t p);
    pend_q.insert(pend_q.size(), p);
  endfunction

  function automatic logic [CRD_W:0] magn(input logic signed [CRD_W-1:0] c);
    return c[CRD_W-1] ? -{c[CRD_W-1], c} : {1'b0, c};
  endfunction

  function automatic logic [RANGE_W-1:0] floor_sqrt(input logic [63:0] v);
    logic [RANGE_W-1:0] r, t;
    logic [63:0]        tt;
    r = '0;
    for (int b = RANGE_W - 1; b >= 0; b--) begin
      t  = r | (19'd1 << b);
      tt = 64'(t);
      if (tt * tt <= v) r = t;
    end
    return r;
  endfunction

  // Filter model: updates frame state and queues the point if it is kept
  function automatic void predict_kept(input point_t p);
    logic [DEC_W:0]   dec_eff, ph_inc;
    logic [DEC_W-1:0] ph;
    bit               had, same, solid, ok;
    logic [63:0]      r2, lim_lo, lim_hi;
    kept_t            e;
    n_points++;
    if (p.frame_start) begin
      idx_phase = '0;
      seen      = 1'b0;
      prev_x    = '0;
      prev_y    = '0;
      prev_z    = '0;
    end
    if (!p.point_finite) return;

    dec_eff = (dec_q == 0) ? 17'd1 : {1'b0, dec_q};
    ph      = idx_phase;
    had     = seen;
    same    = had && p.x == prev_x && p.y == prev_y && p.z == prev_z;
    ph_inc  = {1'b0, ph} + 17'd1;
    // every counted point advances the phase and becomes the previous point
    idx_phase = (ph_inc >= dec_eff) ? '0 : ph_inc[DEC_W-1:0];
    seen      = 1'b1;
    prev_x    = p.x;
    prev_y    = p.y;
    prev_z    = p.z;
    if (ph != 0 && {1'b0, ph} < dec_eff) return;

    r2     = magn(p.x) * magn(p.x) + magn(p.y) * magn(p.y) + magn(p.z) * magn(p.z);
    lim_lo = min_q * min_q;
    lim_hi = max_q * max_q;
    solid  = (mode_q == MODE_SOLID);
    if (solid) begin
      if ((p.tag & TAG_FIELD_MASK) != TAG_RET_ONE &&
          (p.tag & TAG_FIELD_MASK) != TAG_RET_NONE) return;
      if (!had || same) return;
      ok = r2 > lim_lo && r2 < lim_hi;
    end else begin
      ok = r2 >= lim_lo && r2 <= lim_hi;
    end
    if (!ok) return;

    e.x     = p.x;
    e.y     = p.y;
    e.z     = p.z;
    e.inten = p.inten;
    e.ring  = solid ? '0 : p.ring;
    e.t_us  = (mode_q == MODE_SPIN_US) ? p.raw_t : p.raw_t / 1000;
    e.rng   = solid ? '0 : floor_sqrt(r2);
    kept_q.insert(kept_q.size(), e);
  endfunction

  function automatic void cmp(input string fld, input logic signed [63:0] e,
                              input logic signed [63:0] a);
    if (a !== e) begin
      $error("%s: expected %0d, got %0d", fld, e, a);
      n_errs++;
    end
  endfunction

  function automatic logic signed [CRD_W-1:0] rand_coord();
    logic signed [CRD_W-1:0] c;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       c = CRD_W'(CRD_MIN);
          1:       c = CRD_W'(CRD_MAX);
          2:       c = '0;
          3:       c = '1;
          default: c = CRD_W'(1);
        endcase
      end
      1, 2, 3, 4: c = CRD_W'(int'($urandom_range(0, 6000)) - 3000);
      5, 6, 7:    c = CRD_W'(int'($urandom_range(0, 300000)) - 150000);
      default:    c = CRD_W'($urandom());
    endcase
    return c;
  endfunction

  function automatic point_t gen_point();
    point_t p;
    p.frame_start  = 1'b0;
    p.point_finite = ($urandom_range(0, 9) != 0);
    p.hold         = 1'b0;
    p.x = rand_coord();
    p.y = rand_coord();
    p.z = rand_coord();
    // repeated and all-zero points
    if (have_last && $urandom_range(0, 9) == 0) begin
      p.x = last_gen.x;
      p.y = last_gen.y;
      p.z = last_gen.z;
    end else if ($urandom_range(0, 29) == 0) begin
      p.x = '0;
      p.y = '0;
      p.z = '0;
    end
    if ($urandom_range(0, 4) != 0)
      p.tag = TAG_W'(($urandom() & ~TAG_FIELD_MASK) |
                     ($urandom_range(0, 1) ? TAG_RET_ONE : TAG_RET_NONE));
    else
      p.tag = TAG_W'($urandom());
    p.inten = INT_W'($urandom());
    p.ring  = RING_W'($urandom());
    if ($urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 3))
        0:       p.raw_t = 32'd0;
        1:       p.raw_t = 32'd999;
        2:       p.raw_t = 32'd1000;
        default: p.raw_t = 32'hFFFF_FFFF;
      endcase
    end else begin
      p.raw_t = $urandom();
    end
    last_gen  = p;
    have_last = 1'b1;
    return p;
  endfunction

  function automatic point_t mk_pt(input int fs, input int fin, input int x, input int y,
                                   input int z, input logic [TAG_W-1:0] tag,
                                   input logic [TIME_W-1:0] t);
    point_t p;
    p.frame_start  = (fs != 0);
    p.point_finite = (fin != 0);
    p.x     = CRD_W'(x);
    p.y     = CRD_W'(y);
    p.z     = CRD_W'(z);
    p.tag   = tag;
    p.inten = INT_W'($urandom());
    p.ring  = RING_W'($urandom());
    p.raw_t = t;
    p.hold  = 1'b0;
    return p;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    case (idx)
      CFG_LIDAR_MODE: mode_q = val[MODE_W-1:0];
      CFG_MIN_RANGE:  min_q  = val[LIM_W-1:0];
      CFG_MAX_RANGE:  max_q  = val[LIM_W-1:0];
      CFG_DECIMATION: dec_q  = val[DEC_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Wait for all points sent and all results in, then let the back end drain
  task automatic wait_idle();
    while (pend_q.size() != 0 || pts_in.valid || kept_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // One register setting followed by framed random points; the first segment
  // continues the previous frame so that settings change mid-frame
  task automatic run_phase(input logic [MODE_W-1:0] md, input logic [LIM_W-1:0] lo_mm,
                           input logic [LIM_W-1:0] hi_mm, input logic [DEC_W-1:0] dv,
                           input int n);
    int     cnt, len;
    bit     cont, broken;
    point_t p;
    wait_idle();
    write_reg(CFG_LIDAR_MODE, CFG_DATA_W'(md));
    write_reg(CFG_MIN_RANGE, lo_mm);
    write_reg(CFG_MAX_RANGE, hi_mm);
    write_reg(CFG_DECIMATION, CFG_DATA_W'(dv));
    n_cfgs++;
    cnt  = 0;
    cont = 1'b1;
    while (cnt < n) begin
      len    = cont ? $urandom_range(0, 5) : $urandom_range(1, 24);
      broken = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < len && cnt < n; k++) begin
        p = gen_point();
        p.frame_start = broken ? 1'($urandom_range(0, 1)) : (k == 0 && !cont);
        p.hold        = (cnt == n / 2);
        queue_pt(p);
        cnt++;
      end
      cont = 1'b0;
    end
  endtask

  // Point driver: one item per launch, random gap after each accepted item
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pts_in.valid <= 1'b0;
    end else if (!pts_in.valid || pt_taken) begin
      if (gap_cnt != 0) begin
        gap_cnt--;
        pts_in.valid <= 1'b0;
      end else if (pend_q.size() != 0 && !(pend_q[0].hold && kept_q.size() != 0)) begin
        cur_pt = pend_q.pop_front();
        pts_in.frame_start  <= cur_pt.frame_start;
        pts_in.point_finite <= cur_pt.point_finite;
        pts_in.x_mm         <= cur_pt.x;
        pts_in.y_mm         <= cur_pt.y;
        pts_in.z_mm         <= cur_pt.z;
        pts_in.return_tag   <= cur_pt.tag;
        pts_in.intensity_in <= cur_pt.inten;
        pts_in.ring_in      <= cur_pt.ring;
        pts_in.raw_time     <= cur_pt.raw_t;
        pts_in.valid        <= 1'b1;
        // occasionally switch between gapped and back-to-back stretches
        if ($urandom_range(0, 39) == 0) quiet = !quiet;
        gap_cnt = quiet ? 0 : $urandom_range(0, 4);
      end else begin
        pts_in.valid <= 1'b0;
      end
    end
  end

  // Result side: random stall after each accepted result
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pts_out.ready <= 1'b0;
    end else begin
      if (res_taken) stall_cnt = quiet ? 0 : $urandom_range(0, 4);
      if (stall_cnt != 0) begin
        stall_cnt--;
        pts_out.ready <= 1'b0;
      end else begin
        pts_out.ready <= 1'b1;
      end
    end
  end

  // Monitor: checks kept points, models accepted input points, watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt >= LIMIT_CYC) begin
      $display("tb_lidar_point_range_filter_unit: errors");
      $finish;
    end
    pt_taken  <= rst_ni && pts_in.valid && pts_in.ready;
    res_taken <= rst_ni && pts_out.valid && pts_out.ready;
    if (rst_ni && pts_out.valid && pts_out.ready) begin
      if (kept_q.size() == 0) begin
        $error("unexpected kept point x_out=%0d y_out=%0d z_out=%0d",
               pts_out.x_out, pts_out.y_out, pts_out.z_out);
        n_errs++;
      end else begin
        head = kept_q.pop_front();
        n_kept++;
        cmp("x_out", head.x, pts_out.x_out);
        cmp("y_out", head.y, pts_out.y_out);
        cmp("z_out", head.z, pts_out.z_out);
        cmp("intensity_out", head.inten, pts_out.intensity_out);
        cmp("ring_out", head.ring, pts_out.ring_out);
        cmp("time_us", head.t_us, pts_out.time_us);
        cmp("range_mm", head.rng, pts_out.range_mm);
      end
    end
    if (rst_ni && pts_in.valid && pts_in.ready) predict_kept(cur_pt);
  end

  // Reset, directed points, register settings and random phases
  initial begin
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_LIDAR_MODE;
    cfg_data_i          = '0;
    pts_in.valid        = 1'b0;
    pts_in.frame_start  = 1'b0;
    pts_in.point_finite = 1'b0;
    pts_in.x_mm         = '0;
    pts_in.y_mm         = '0;
    pts_in.z_mm         = '0;
    pts_in.return_tag   = '0;
    pts_in.intensity_in = '0;
    pts_in.ring_in      = '0;
    pts_in.raw_time     = '0;
    pts_out.ready       = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Solid-state at reset settings: first point, repeat, tag codes, NaN,
    // strict limits, frame start on a NaN point
    n_cfgs++;
    queue_pt(mk_pt(1, 1, 100, 0, 0, TAG_RET_NONE, 32'd5000));
    queue_pt(mk_pt(0, 1, 100, 0, 0, TAG_RET_NONE, 32'd6000));
    queue_pt(mk_pt(0, 1, 200, 0, 0, TAG_RET_ONE, 32'd1999));
    queue_pt(mk_pt(0, 1, 300, 0, 0, TAG_RET_TWO, 32'd1000));
    queue_pt(mk_pt(0, 1, 400, 0, 0, TAG_FIELD_MASK, 32'd1000));
    queue_pt(mk_pt(0, 0, 500, 0, 0, TAG_RET_NONE, 32'd1000));
    queue_pt(mk_pt(0, 1, 0, 0, 0, TAG_RET_NONE, 32'd0));
    queue_pt(mk_pt(0, 1, CRD_MAX, 0, 0, TAG_RET_NONE, 32'd999));
    queue_pt(mk_pt(0, 1, CRD_MAX - 1, 0, 0, TAG_RET_ONE, 32'hFFFF_FFFF));
    queue_pt(mk_pt(0, 1, CRD_MIN, CRD_MIN, CRD_MIN, TAG_RET_NONE, 32'd0));
    queue_pt(mk_pt(1, 0, 7, 7, 7, TAG_RET_NONE, 32'd0));
    queue_pt(mk_pt(0, 1, 5, 5, 5, TAG_RET_NONE, 32'd0));
    queue_pt(mk_pt(0, 1, -1, -1, -1, ~TAG_FIELD_MASK, 32'd123456));

    // Spinning, full limits: zero point, repeats kept, points on the limit
    wait_idle();
    write_reg(CFG_LIDAR_MODE, CFG_DATA_W'(MODE_SPIN_NS));
    n_cfgs++;
    queue_pt(mk_pt(1, 1, 0, 0, 0, TAG_RET_NONE, 32'd999));
    queue_pt(mk_pt(0, 1, 0, 0, 0, TAG_FIELD_MASK, 32'd1000));
    queue_pt(mk_pt(0, 1, CRD_MAX, 0, 0, TAG_RET_NONE, 32'hFFFF_FFFF));
    queue_pt(mk_pt(0, 1, 0, CRD_MIN, 0, TAG_RET_NONE, 32'd0));
    queue_pt(mk_pt(0, 1, 3, 4, 0, TAG_FIELD_MASK, 32'd77777));
    queue_pt(mk_pt(0, 1, CRD_MAX, CRD_MAX, CRD_MAX, TAG_RET_NONE, 32'd0));
    queue_pt(mk_pt(0, 1, -1000, 2000, -2000, TAG_RET_TWO, 32'd0));

    run_phase(MODE_SPIN_US, 18'd500, 18'd100000, 16'd2, 110);
    run_phase(MODE_SOLID, 18'd100, 18'd50000, 16'd3, 110);
    run_phase(MODE_SPIN_NS, MIN_RANGE_RST, MAX_RANGE_RST, DECIMATION_RST, 110);
    run_phase(MODE_SOLID, MIN_RANGE_RST, MAX_RANGE_RST, 16'd2, 100);
    run_phase(MODE_SPIN_ALT, MAX_RANGE_RST, MAX_RANGE_RST, 16'hFFFF, 40);
    run_phase(MODE_SPIN_NS, 18'd5000, 18'd4000, 16'd0, 40);
    run_phase(MODE_SPIN_US, 18'd0, 18'd0, DECIMATION_RST, 40);
    run_phase(MODE_SPIN_NS, 18'd1, 18'd200000, 16'd7, 100);
    run_phase(MODE_SOLID, 18'd0, 18'd262000, DECIMATION_RST, 60);
    wait_idle();

    $display("%0d points sent, %0d kept points checked field by field", n_points, n_kept);
    $display("%0d register settings: all modes, decimation 0 to 65535, limit extremes",
             n_cfgs);
    if (n_errs == 0) begin
      $display("tb_lidar_point_range_filter_unit: clean");
    end else begin
      $display("tb_lidar_point_range_filter_unit: errors");
    end
    $finish;
  end

endmodule
